>>> sv/npt_pkg.sv
// Package for the nearest point table: item types, command and status codes,
// controller states and default sizes. No dependencies.
package npt_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MEMBER  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEAREST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [INDEX_W-1:0]  match_index;
        logic [COUNT_W-1:0]  point_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

>>> sv/npt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module npt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/npt_scan.sv
// Scan datapath of the nearest point table: exact-match search and
// squared-distance minimum over entries streamed from the point RAM.
// Depends on npt_pkg.
module npt_scan import npt_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW = COORD_BITS,
    localparam int DW = 2 * COORD_BITS + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_rd_valid,
    input  logic [IW-1:0]   i_rd_idx,
    input  logic [2*CW-1:0] i_rdata,
    input  logic [CW-1:0]   i_qx,
    input  logic [CW-1:0]   i_qy,
    output logic            o_busy,
    output logic            o_hit,
    output logic [IW-1:0]   o_hit_idx,
    output logic [IW-1:0]   o_best_idx
);

    logic [CW-1:0]   px;
    logic [CW-1:0]   py;
    logic [CW-1:0]   n_dx;
    logic [CW-1:0]   n_dy;
    logic [DW-1:0]   sq_dist;

    logic            r1_v;
    logic [IW-1:0]   r1_idx;
    logic            r1_eq;
    logic [CW-1:0]   r1_dx;
    logic [CW-1:0]   r1_dy;

    logic            r2_v;
    logic [IW-1:0]   r2_idx;
    logic [2*CW-1:0] r2_dx2;
    logic [2*CW-1:0] r2_dy2;

    logic            r_first;
    logic [DW-1:0]   r_best;
    logic [IW-1:0]   r_best_idx;
    logic            r_hit;
    logic [IW-1:0]   r_hit_idx;

    assign px      = i_rdata[2*CW-1:CW];
    assign py      = i_rdata[CW-1:0];
    assign n_dx    = (i_qx >= px) ? (i_qx - px) : (px - i_qx);
    assign n_dy    = (i_qy >= py) ? (i_qy - py) : (py - i_qy);
    assign sq_dist = {1'b0, r2_dx2} + {1'b0, r2_dy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_first <= 1'b1;
            r_hit   <= 1'b0;
        end else begin
            r1_v <= i_rd_valid;
            r2_v <= r1_v;
            if (i_clear) begin
                r_first <= 1'b1;
                r_hit   <= 1'b0;
            end else begin
                if (r1_v && r1_eq && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (r2_v) begin
                    r_first <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_idx <= i_rd_idx;
        r1_eq  <= (px == i_qx) && (py == i_qy);
        r1_dx  <= n_dx;
        r1_dy  <= n_dy;
        r2_idx <= r1_idx;
        r2_dx2 <= r1_dx * r1_dx;
        r2_dy2 <= r1_dy * r1_dy;
        if (r1_v && r1_eq && !r_hit) begin
            r_hit_idx <= r1_idx;
        end
        if (r2_v && (r_first || (sq_dist < r_best))) begin
            r_best     <= sq_dist;
            r_best_idx <= r2_idx;
        end
    end

    assign o_busy     = r1_v || r2_v;
    assign o_hit      = r_hit;
    assign o_hit_idx  = r_hit_idx;
    assign o_best_idx = r_best_idx;

endmodule

>>> sv/nearest_point_table_top.sv
// Nearest point table: each item scans the N stored entries, none for an
// empty table or an unused command. One item at a time: a new item is taken
// only once the last result is loaded for output; the point RAM's single read
// port streams one entry per cycle. Synchronous active-low reset clears the
// count and control state; the RAM is not cleared.
// Top level; depends on npt_pkg, npt_ram and npt_scan.
module nearest_point_table_top import npt_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int CW   = COORD_BITS;

    t_state           r_state;
    t_state           n_state;
    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  n_count;
    logic [IW-1:0]    r_addr;
    logic [IW-1:0]    n_addr;
    logic             r_rd_v;
    logic [IW-1:0]    r_rd_idx;
    logic [CMD_W-1:0] r_cmd;
    logic [CW-1:0]    r_qx;
    logic [CW-1:0]    r_qy;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             accept;
    logic             rd_en;
    logic             we;
    logic             load_out;
    logic [2*CW-1:0]  rdata;
    logic             scan_busy;
    logic             hit;
    logic [IW-1:0]    hit_idx;
    logic [IW-1:0]    best_idx;
    logic [IW-1:0]    last_addr;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign last_addr = IW'(r_count - CNTW'(1));

    npt_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (IW'(r_count)),
        .i_wdata ({r_qx, r_qy}),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    npt_scan #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (accept),
        .i_rd_valid (r_rd_v),
        .i_rd_idx   (r_rd_idx),
        .i_rdata    (rdata),
        .i_qx       (r_qx),
        .i_qy       (r_qy),
        .o_busy     (scan_busy),
        .o_hit      (hit),
        .o_hit_idx  (hit_idx),
        .o_best_idx (best_idx)
    );

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_count  = r_count;
        rd_en    = 1'b0;
        we       = 1'b0;
        load_out = 1'b0;
        n_out    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr = '0;
                    if (r_count == '0) begin
                        n_state = S_DONE;
                    end else if (i_item.cmd inside {CMD_ADD, CMD_MEMBER, CMD_NEAREST}) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                rd_en = 1'b1;
                if (r_addr == last_addr) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + IW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_rd_v && !scan_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                case (r_cmd)
                    CMD_ADD: begin
                        if (hit) begin
                            n_out.status      = ST_DUP;
                            n_out.match_index = INDEX_W'(hit_idx);
                        end else if (r_count == CNTW'(MAX_POINTS)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            n_out.match_index = INDEX_W'(r_count);
                            n_count           = r_count + CNTW'(1);
                        end
                    end
                    CMD_MEMBER: begin
                        n_out.found = hit;
                        if (hit) begin
                            n_out.match_index = INDEX_W'(hit_idx);
                        end
                    end
                    CMD_NEAREST: begin
                        if (r_count == '0) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_out.found       = 1'b1;
                            n_out.match_index = INDEX_W'(best_idx);
                        end
                    end
                    default: begin
                    end
                endcase
                n_out.point_count = COUNT_W'(n_count);
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    we       = (n_count != r_count);
                    n_state  = S_IDLE;
                end else begin
                    n_count = r_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_v  <= rd_en;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_rd_idx <= r_addr;
        if (accept) begin
            r_cmd <= i_item.cmd;
            r_qx  <= CW'(i_item.pos_x);
            r_qy  <= CW'(i_item.pos_y);
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_POINTS))
        else $error("stored count above table size");

    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNTW'(r_addr) < r_count))
        else $error("scan address beyond stored count");

    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("point write without count advance");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state) == S_DRAIN) |-> (!scan_busy && !r_rd_v))
        else $error("result taken while scan pipeline busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result changed before taken");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for nearest_point_table_top: add, membership, nearest and unused items
// with random idling on both sides, each result checked against a local copy of
// the point list. Depends on npt_pkg and the nearest_point_table_top RTL.
module tb_top;
    import npt_pkg::*;

    localparam int NUM_POINTS = MAX_POINTS_DEF;
    localparam int SETTLE_CYCLES = NUM_POINTS + 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    nearest_point_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    logic [POS_W-1:0] pt_x [NUM_POINTS];
    logic [POS_W-1:0] pt_y [NUM_POINTS];
    int               pt_count = 0;
    t_out_item        pending_answers [$];
    int               err_count = 0;
    bit               src_idle_on = 1'b1;
    bit               snk_idle_on = 1'b1;
    int               long_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int find_point(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        for (int i = 0; i < pt_count; i++) begin
            if (pt_x[i] == x && pt_y[i] == y) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_out_item apply_point_cmd(t_in_item it);
        t_out_item       ans;
        int              hit;
        longint unsigned best;
        longint unsigned sq_dist;
        longint unsigned dx;
        longint unsigned dy;
        ans = '0;
        ans.status = ST_OK;
        hit = find_point(it.pos_x, it.pos_y);
        case (it.cmd)
            CMD_ADD: begin
                if (hit >= 0) begin
                    ans.status = ST_DUP;
                    ans.match_index = INDEX_W'(hit);
                end else if (pt_count >= NUM_POINTS) begin
                    ans.status = ST_FULL;
                end else begin
                    pt_x[pt_count] = it.pos_x;
                    pt_y[pt_count] = it.pos_y;
                    ans.match_index = INDEX_W'(pt_count);
                    pt_count++;
                end
            end
            CMD_MEMBER: begin
                if (hit >= 0) begin
                    ans.found = 1'b1;
                    ans.match_index = INDEX_W'(hit);
                end
            end
            CMD_NEAREST: begin
                if (pt_count == 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 0; i < pt_count; i++) begin
                        dx = (it.pos_x >= pt_x[i]) ? it.pos_x - pt_x[i] : pt_x[i] - it.pos_x;
                        dy = (it.pos_y >= pt_y[i]) ? it.pos_y - pt_y[i] : pt_y[i] - it.pos_y;
                        sq_dist = dx * dx + dy * dy;
                        if (i == 0 || sq_dist < best) begin
                            best = sq_dist;
                            ans.match_index = INDEX_W'(i);
                        end
                    end
                    ans.found = 1'b1;
                end
            end
            default: begin
            end
        endcase
        ans.point_count = COUNT_W'(pt_count);
        return ans;
    endfunction

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item point_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] x,
                                            logic [POS_W-1:0] y);
        t_in_item it;
        it.cmd = cmd;
        it.pos_x = x;
        it.pos_y = y;
        return it;
    endfunction

    function automatic t_in_item make_rand_item(int add_pct);
        t_in_item it;
        int       r;
        int       k;
        int       idx;
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
            it.cmd = CMD_ADD;
        end else if (r < add_pct + 4) begin
            it.cmd = CMD_UNUSED;
        end else if (r < add_pct + 4 + (96 - add_pct) * 2 / 5) begin
            it.cmd = CMD_MEMBER;
        end else begin
            it.cmd = CMD_NEAREST;
        end
        k = $urandom_range(0, 9);
        if (k < 3 && pt_count > 0) begin
            idx = $urandom_range(0, pt_count - 1);
            it.pos_x = pt_x[idx];
            it.pos_y = pt_y[idx];
            if (k == 2) begin
                it.pos_x = it.pos_x + POS_W'($urandom_range(0, 2)) - 1'b1;
            end
        end else if (k < 6) begin
            it.pos_x = POS_W'($urandom_range(0, 15));
            it.pos_y = POS_W'($urandom_range(0, 15));
        end else if (k < 9) begin
            it.pos_x = POS_W'($urandom());
            it.pos_y = POS_W'($urandom());
        end else begin
            it.pos_x = $urandom_range(0, 1) ? POS_MAX : '0;
            it.pos_y = $urandom_range(0, 1) ? POS_MAX : '0;
        end
        return it;
    endfunction

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_answers.push_back(apply_point_cmd(it));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    initial begin : sink_ctl
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_cycles > 0) begin
                stall = long_hold_cycles;
                long_hold_cycles = 0;
            end else if (stall == 0 && snk_idle_on && $urandom_range(0, 3) == 0) begin
                stall = pick_gap(1'b1);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                flag_error($sformatf("unexpected result: status %0d found %0b index %0d count %0d",
                                     o_item.status, o_item.found, o_item.match_index,
                                     o_item.point_count));
            end else begin
                want = pending_answers.pop_front();
                if (o_item.status !== want.status || o_item.found !== want.found ||
                    o_item.match_index !== want.match_index ||
                    o_item.point_count !== want.point_count) begin
                    flag_error($sformatf({"mismatch: expected status %0d found %0b index %0d ",
                                          "count %0d, got status %0d found %0b index %0d ",
                                          "count %0d"},
                                         want.status, want.found, want.match_index,
                                         want.point_count, o_item.status, o_item.found,
                                         o_item.match_index, o_item.point_count));
                end
            end
        end
    end

    task automatic test_empty_table();
        send_item(point_item(CMD_NEAREST, POS_MAX, '0));
        send_item(point_item(CMD_MEMBER, '0, '0));
        send_item(point_item(CMD_UNUSED, POS_MAX, POS_MAX));
    endtask

    task automatic test_add_member();
        send_item(point_item(CMD_ADD, '0, '0));
        send_item(point_item(CMD_ADD, POS_MAX, POS_MAX));
        send_item(point_item(CMD_ADD, '0, '0));
        send_item(point_item(CMD_ADD, POS_MAX, POS_MAX));
        send_item(point_item(CMD_MEMBER, POS_MAX, POS_MAX));
        send_item(point_item(CMD_MEMBER, POS_MAX, '0));
    endtask

    task automatic test_nearest_ties();
        send_item(point_item(CMD_NEAREST, '0, '0));
        send_item(point_item(CMD_NEAREST, POS_MAX, POS_MAX));
        send_item(point_item(CMD_NEAREST, 16'd32767, 16'd32768));
        send_item(point_item(CMD_ADD, 16'd100, 16'd200));
        send_item(point_item(CMD_ADD, 16'd300, 16'd200));
        send_item(point_item(CMD_NEAREST, 16'd200, 16'd200));
        send_item(point_item(CMD_NEAREST, 16'd200, 16'd201));
        send_item(point_item(CMD_ADD, '0, POS_MAX));
        send_item(point_item(CMD_ADD, POS_MAX, '0));
        send_item(point_item(CMD_NEAREST, POS_MAX, 16'd1));
        send_item(point_item(CMD_MEMBER, '0, POS_MAX));
    endtask

    task automatic test_unused_cmd();
        send_item(point_item(CMD_UNUSED, '0, '0));
        send_item(point_item(CMD_UNUSED, 16'h5a5a, 16'ha5a5));
    endtask

    task automatic test_random_mix(int n, int add_pct);
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                snk_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_item(make_rand_item(add_pct));
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        src_idle_on = 1'b0;
        long_hold_cycles = 300;
        repeat (12) send_item(make_rand_item(20));
        src_idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            repeat (8) send_item(make_rand_item(20));
            wait_drained();
        end
    endtask

    task automatic test_fill_table();
        t_in_item it;
        while (pt_count < NUM_POINTS) begin
            send_item(point_item(CMD_ADD, POS_W'($urandom()), POS_W'($urandom())));
        end
        it = point_item(CMD_ADD, POS_W'($urandom()), POS_W'($urandom()));
        while (find_point(it.pos_x, it.pos_y) >= 0) begin
            it.pos_x = POS_W'($urandom());
        end
        send_item(it);
        send_item(point_item(CMD_ADD, pt_x[NUM_POINTS-1], pt_y[NUM_POINTS-1]));
        send_item(point_item(CMD_NEAREST, '0, '0));
        send_item(point_item(CMD_NEAREST, POS_MAX, POS_MAX));
        send_item(point_item(CMD_MEMBER, pt_x[NUM_POINTS-1], pt_y[NUM_POINTS-1]));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_add_member();
        test_nearest_ties();
        test_unused_cmd();
        test_random_mix(700, 12);
        test_backpressure();
        test_drain_pause();
        test_fill_table();
        test_random_mix(750, 20);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/npt_pkg.sv
sv/npt_ram.sv
sv/npt_scan.sv
sv/nearest_point_table_top.sv
sim/tb_top.sv
